// ----- src/fsgd_pkg.sv -----
package fsgd_pkg;

  // Fixed formats of the pixel fields
  localparam int IN_W      = 16;
  localparam int GRAY_W    = 8;
  localparam int FRAC_BITS = 8;
  localparam int EBITS     = FRAC_BITS + 4;
  localparam int ERR_W     = EBITS;
  localparam int ACC_W     = 16;
  localparam int SUM_W     = IN_W + (EBITS - FRAC_BITS) + 2;
  localparam int CLAMP_W   = GRAY_W + EBITS;

  // Configuration
  localparam int LW_W = 12;
  localparam logic [LW_W-1:0] LW_RESET = LW_W'(1024);
  localparam int MAX_WIDTH_DEF = 2048;

  typedef struct packed {
    logic frame_start;
    logic first_row;
    logic last;
  } pix_ctl_t;

  typedef struct packed {
    logic                    en;
    logic signed [ACC_W-1:0] data;
  } store_wr_t;

endpackage

// ----- src/fsgd_store.sv -----
module fsgd_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [AW-1:0]                   raddr,
  input  logic [AW-1:0]                   hold_addr,
  input  fsgd_pkg::store_wr_t             wr,
  input  logic [AW-1:0]                   waddr,
  output logic signed [fsgd_pkg::ACC_W-1:0] rdata,
  output logic                            busy
);
  import fsgd_pkg::*;

  logic signed [ACC_W-1:0] mem [DEPTH];
  logic signed [ACC_W-1:0] rd_q;
  logic signed [ACC_W-1:0] byp;
  logic                    byp_hit;
  logic [AW-1:0]           clr_addr;
  logic [AW-1:0]           tgt;

  // Sweep zeros through the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[waddr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  // Catch writes that land on the entry being read or held
  assign tgt = rd_en ? raddr : hold_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (wr.en && !busy && waddr == tgt) begin
      byp_hit <= 1'b1;
    end else if (rd_en) begin
      byp_hit <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && waddr == tgt) begin
      byp <= wr.data;
    end
  end

  assign rdata = byp_hit ? byp : rd_q;

endmodule

// ----- src/fsgd_front.sv -----
module fsgd_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int AW        = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fsgd_pkg::IN_W-1:0]     in_ideal,
  input  logic                          in_frame_start,
  input  logic [fsgd_pkg::LW_W-1:0]     line_width,
  input  logic                          busy,
  input  logic                          adv,
  output logic                          s1_valid,
  output logic [fsgd_pkg::IN_W-1:0]     s1_ideal,
  output logic [AW-1:0]                 s1_x,
  output fsgd_pkg::pix_ctl_t            s1_ctl,
  output logic                          rd_en,
  output logic [AW-1:0]                 raddr
);
  import fsgd_pkg::*;

  localparam int CW = (AW + 1 > LW_W) ? AW + 1 : LW_W;

  logic [AW-1:0] column_count;
  logic          first_row;
  logic [AW-1:0] x_in;
  logic          fr_in;
  logic          last_in;
  logic [CW-1:0] w_eff;
  logic [CW-1:0] lw_ext;
  logic          accept;

  assign lw_ext = CW'(line_width);

  always_comb begin
    priority if (lw_ext == '0) begin
      w_eff = CW'(1);
    end else if (lw_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
  end

  assign in_ready = !busy && (!s1_valid || adv);
  assign accept   = in_valid && in_ready;
  assign x_in     = in_frame_start ? '0 : column_count;
  assign fr_in    = in_frame_start || first_row;
  assign last_in  = (CW'(x_in) + CW'(1)) >= w_eff;

  assign rd_en = accept;
  assign raddr = x_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= last_in ? '0 : x_in + 1'b1;
        first_row    <= fr_in && !last_in;
        s1_valid     <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ideal           <= in_ideal;
      s1_x               <= x_in;
      s1_ctl.frame_start <= in_frame_start;
      s1_ctl.first_row   <= fr_in;
      s1_ctl.last        <= last_in;
    end
  end

endmodule

// ----- src/fsgd_core.sv -----
module fsgd_core #(
  parameter int AW = 11
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s1_valid,
  input  logic [fsgd_pkg::IN_W-1:0]         s1_ideal,
  input  logic [AW-1:0]                     s1_x,
  input  fsgd_pkg::pix_ctl_t                s1_ctl,
  input  logic signed [fsgd_pkg::ACC_W-1:0] store_rdata,
  output logic                              adv,
  output fsgd_pkg::store_wr_t               wr,
  output logic [AW-1:0]                     waddr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fsgd_pkg::GRAY_W-1:0]       out_gray,
  output logic                              out_last
);
  import fsgd_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(((2 ** GRAY_W) - 1) * (2 ** EBITS));
  localparam logic [CLAMP_W:0] HALF = (CLAMP_W + 1)'(2 ** (EBITS - 1));

  logic signed [ACC_W-1:0] right_carry;
  logic signed [ACC_W-1:0] below_left_acc;
  logic signed [ACC_W-1:0] below_acc;
  logic                    pend_valid;
  logic [AW-1:0]           pend_addr;
  logic signed [ACC_W-1:0] pend_data;

  logic                    take;
  logic signed [ACC_W-1:0] rc, bla, ba, sv, sv_raw;
  logic signed [SUM_W-1:0] ideal_s, owed, sum;
  logic [CLAMP_W-1:0]      cs;
  logic [CLAMP_W:0]        rnd;
  logic [GRAY_W-1:0]       gray;
  logic [CLAMP_W:0]        diff;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W+2:0] err_x, m7, m3, m5;
  logic signed [ACC_W-1:0] e7, e3, e5, e1;
  logic signed [ACC_W-1:0] bl_store, bl_new;

  assign adv  = !out_valid || out_ready;
  assign take = s1_valid && adv;

  // Owed error: frame start drops the line state, first row ignores the store
  assign rc  = s1_ctl.frame_start ? '0 : right_carry;
  assign bla = s1_ctl.frame_start ? '0 : below_left_acc;
  assign ba  = s1_ctl.frame_start ? '0 : below_acc;

  assign sv_raw = (pend_valid && pend_addr == s1_x) ? pend_data : store_rdata;
  assign sv     = s1_ctl.first_row ? '0 : sv_raw;

  assign ideal_s = $signed(SUM_W'(s1_ideal) << (EBITS - FRAC_BITS));
  assign owed    = SUM_W'(rc) + SUM_W'(sv);
  assign sum     = ideal_s + owed;

  always_comb begin
    priority if (sum < 0) begin
      cs = '0;
    end else if (sum > SAT_MAX) begin
      cs = SAT_MAX[CLAMP_W-1:0];
    end else begin
      cs = sum[CLAMP_W-1:0];
    end
  end

  // Round to nearest, ties up
  assign rnd  = {1'b0, cs} + HALF;
  assign gray = rnd[EBITS +: GRAY_W];
  assign diff = {1'b0, cs} - {1'b0, gray, {EBITS{1'b0}}};
  assign err  = $signed(diff[ERR_W-1:0]);

  assign err_x = (ERR_W + 3)'(err);
  assign m7    = (err_x <<< 3) - err_x;
  assign m3    = (err_x <<< 1) + err_x;
  assign m5    = (err_x <<< 2) + err_x;
  assign e7    = ACC_W'(m7 >>> 4);
  assign e3    = ACC_W'(m3 >>> 4);
  assign e5    = ACC_W'(m5 >>> 4);
  assign e1    = ACC_W'(err) - e7 - e3 - e5;

  assign bl_store = bla + e3;
  assign bl_new   = ba + e5;

  // The last column's entry goes out in the next cycle; next pixel is column 0
  always_comb begin
    if (pend_valid) begin
      wr.en   = 1'b1;
      wr.data = pend_data;
      waddr   = pend_addr;
    end else begin
      wr.en   = take && (s1_x != '0);
      wr.data = bl_store;
      waddr   = s1_x - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_carry    <= '0;
      below_left_acc <= '0;
      below_acc      <= '0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      pend_valid <= take && s1_ctl.last;
      if (take) begin
        if (s1_ctl.last) begin
          right_carry    <= '0;
          below_left_acc <= '0;
          below_acc      <= '0;
        end else begin
          right_carry    <= e7;
          below_left_acc <= bl_new;
          below_acc      <= e1;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_addr <= s1_x;
      pend_data <= bl_new;
      out_gray  <= gray;
      out_last  <= s1_ctl.last;
    end
  end

endmodule

// ----- src/floyd_steinberg_gray_dither.sv -----
// Floyd-Steinberg error-diffusion dither for a gray pixel stream.
// Input stream: one pixel per item in raster order; s_tdata carries the
// ideal gray in unsigned 8.8, s_tuser marks the first pixel of a frame,
// which drops all error owed from the previous image.
// Output stream: one 8-bit dithered gray per pixel in m_tdata, m_tlast on
// the last pixel of each line (line length from the line_width register).
// Throughput is one pixel per clock outside the reset sweep and while
// m_tready is high. Each pixel gets the error owed by the row above from a
// one-port-read, one-port-write line memory in the cycle after accept, and
// the right-hand error carry closes in the compute stage. Reset: the line
// memory is cleared, one entry a cycle; s_tready stays low during that
// sweep, the APB port works at once. line_width (APB offset 0x0) resets
// to 1024; the user must write it only when idle, unenforced by the block.
// Receiver stall: one pixel waits in the output register and one in the
// read stage, then s_tready drops until m_tready returns.
module floyd_steinberg_gray_dither #(
  parameter int MAX_WIDTH = fsgd_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] ideal_gray
  input  logic        s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] gray
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fsgd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic REG_LINE_WIDTH = 1'b0;

  logic [LW_W-1:0]         line_width;
  logic                    busy;
  logic                    adv;
  logic                    s1_valid;
  logic [IN_W-1:0]         s1_ideal;
  logic [AW-1:0]           s1_x;
  pix_ctl_t                s1_ctl;
  logic                    rd_en;
  logic [AW-1:0]           raddr;
  store_wr_t               wr;
  logic [AW-1:0]           waddr;
  logic signed [ACC_W-1:0] store_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LW_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_WIDTH) begin
      line_width <= pwdata[LW_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LINE_WIDTH) ? 32'(line_width) : '0;

  fsgd_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_ideal(s_tdata),
    .in_frame_start(s_tuser),
    .line_width(line_width),
    .busy(busy),
    .adv(adv),
    .s1_valid(s1_valid),
    .s1_ideal(s1_ideal),
    .s1_x(s1_x),
    .s1_ctl(s1_ctl),
    .rd_en(rd_en),
    .raddr(raddr)
  );

  fsgd_store #(
    .DEPTH(MAX_WIDTH),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .rd_en(rd_en),
    .raddr(raddr),
    .hold_addr(s1_x),
    .wr(wr),
    .waddr(waddr),
    .rdata(store_rdata),
    .busy(busy)
  );

  fsgd_core #(
    .AW(AW)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .s1_valid(s1_valid),
    .s1_ideal(s1_ideal),
    .s1_x(s1_x),
    .s1_ctl(s1_ctl),
    .store_rdata(store_rdata),
    .adv(adv),
    .wr(wr),
    .waddr(waddr),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_gray(m_tdata),
    .out_last(m_tlast)
  );

  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("line memory sweep did not start after reset");

  a_no_out_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !m_tvalid && !s_tready)
    else $error("item moved during line memory sweep");

  a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready && !busy |-> m_tvalid && !m_tready)
    else $error("input stalled without an output stall");

endmodule
